// File: rtl/rpn_pkg.sv
`timescale 1ns / 1ps

package rpn_pkg;

  localparam int DEF_STACK_DEPTH   = 16;
  localparam int DEF_FRACTION_BITS = 16;

  // item kinds
  localparam logic [1:0] KIND_PUSH  = 2'd0;
  localparam logic [1:0] KIND_OP    = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // operator codes
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_UNDER   = 3'd1;
  localparam logic [2:0] ST_OVER    = 3'd2;
  localparam logic [2:0] ST_DIVZERO = 3'd3;
  localparam logic [2:0] ST_SAT     = 3'd4;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] number;
    logic [1:0]         operator_code;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] top_value;
    logic [4:0]         stack_level;
    logic [2:0]         status;
  } out_item_t;

endpackage

// File: rtl/rpn_divider.sv
`timescale 1ns / 1ps

module rpn_divider import rpn_pkg::*; #(
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  localparam int DW = 32 + FRACTION_BITS;
  localparam int CW = $clog2(DW + 1);

  logic [31:0]   rem_r;
  logic [63:0]   quo_r;
  logic [31:0]   dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [33:0]   diff;
  logic          borrow;

  // trial subtract of the divisor from the shifted partial remainder
  assign diff   = {1'b0, rem_r, quo_r[63]} - {2'b00, dvs_r};
  assign borrow = diff[33];

  // dividend sits at the top of quo_r, scaled by 2^FRACTION_BITS through the
  // zero bits below it; quotient bits shift in at the bottom
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
        rem_r  <= '0;
        quo_r  <= {dividend, 32'd0};
        dvs_r  <= divisor;
      end else if (busy_r) begin
        quo_r <= {quo_r[62:0], ~borrow};
        rem_r <= borrow ? {rem_r[30:0], quo_r[63]} : diff[31:0];
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: rtl/rpn_stack_evaluator.sv
`timescale 1ns / 1ps
// Path from the input transfer to out_valid rising: push, clear, unused kind, underflow
// and overflow pass S_IDLE, S_FIN; add, subtract and divide by zero S_IDLE, S_READ, S_FIN;
// multiply S_IDLE, S_READ, S_MUL, S_SAT, S_FIN; divide S_IDLE, S_READ, S_DIV, S_SAT, S_FIN,
// with S_DIV waiting on the divider retiring one quotient bit per cycle. One item in flight:
// the next transfer comes at earliest the cycle after the result loads into the output register.
// Synchronous active-low reset empties the stack; stack memory contents stay undefined.
module rpn_stack_evaluator import rpn_pkg::*; #(
  parameter int STACK_DEPTH   = DEF_STACK_DEPTH,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);
  localparam logic [SPW-1:0] SP_TWO  = SPW'(2);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_MUL, S_DIV, S_SAT, S_FIN
  } state_t;

  // control state
  state_t          state_r, state_nxt;
  logic [SPW-1:0]  sp_r, sp_nxt;
  logic            out_valid_r, out_valid_nxt;

  // payload registers
  logic [31:0]        tos_r, tos_nxt;   // cached copy of the entry at sp-1
  logic [1:0]         op_r, op_nxt;
  logic [2:0]         status_r, status_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  logic [63:0]        mag_r, mag_nxt;
  logic               neg_r, neg_nxt;
  out_item_t          out_data_r, out_data_nxt;

  // stack memory: one write port, one registered read port
  logic [31:0]   stack_mem [STACK_DEPTH];
  logic [31:0]   rd_data_r;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [31:0]   wr_data;

  // operator datapath
  logic signed [31:0] op_a, op_b;
  logic [31:0]        a_mag, b_mag;
  logic signed [32:0] sum;
  logic [63:0]        p_mag;
  logic               commit_en, commit_sat;
  logic [31:0]        commit_val;
  logic               accept;

  // divider
  logic        div_start, div_done;
  logic [63:0] div_quo;

  rpn_divider #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (a_mag),
    .divisor  (b_mag),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign accept = in_valid && in_ready;

  // A is second from top (read from memory), B is the top (held in tos_r).
  // Every write that can precede the read belongs to an earlier item, so
  // no forwarding is needed; the top itself never comes from memory.
  assign op_a  = rd_data_r;
  assign op_b  = tos_r;
  assign a_mag = op_a[31] ? (32'd0 - op_a) : op_a;
  assign b_mag = op_b[31] ? (32'd0 - op_b) : op_b;
  assign p_mag = prod_r[63] ? (64'd0 - prod_r) : prod_r;

  // both operator reads and operator writes land at sp-2
  assign rd_addr = AW'(sp_r - SP_TWO);

  always_comb begin
    state_nxt     = state_r;
    sp_nxt        = sp_r;
    out_valid_nxt = out_valid_r;
    tos_nxt       = tos_r;
    op_nxt        = op_r;
    status_nxt    = status_r;
    prod_nxt      = prod_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    out_data_nxt  = out_data_r;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = rd_addr;
    wr_data       = '0;
    div_start     = 1'b0;
    commit_en     = 1'b0;
    commit_sat    = 1'b0;
    commit_val    = '0;
    sum           = '0;

    // drop the result once the downstream side takes it
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt     = in_data.operator_code;
          status_nxt = ST_OK;
          state_nxt  = S_FIN;
          case (in_data.kind)
            KIND_PUSH: begin
              if (sp_r >= SP_FULL) begin
                status_nxt = ST_OVER;
              end else begin
                wr_en   = 1'b1;
                wr_addr = AW'(sp_r);
                wr_data = in_data.number;
                tos_nxt = in_data.number;
                sp_nxt  = sp_r + SPW'(1);
              end
            end
            KIND_OP: begin
              if (sp_r < SP_TWO) begin
                status_nxt = ST_UNDER;
              end else begin
                rd_en     = 1'b1;
                state_nxt = S_READ;
              end
            end
            KIND_CLEAR: begin
              sp_nxt = '0;
            end
            default: begin
              // unused kind: leave the stack alone
            end
          endcase
        end
      end

      S_READ: begin
        case (op_r)
          OP_ADD, OP_SUB: begin
            if (op_r == OP_ADD) begin
              sum = {op_a[31], op_a} + {op_b[31], op_b};
            end else begin
              sum = {op_a[31], op_a} - {op_b[31], op_b};
            end
            commit_en  = 1'b1;
            commit_sat = sum[32] != sum[31];
            if (commit_sat) begin
              commit_val = sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
              commit_val = sum[31:0];
            end
          end
          OP_MUL: begin
            prod_nxt  = 64'(op_a) * 64'(op_b);
            state_nxt = S_MUL;
          end
          OP_DIV: begin
            if (op_b == 32'sd0) begin
              status_nxt = ST_DIVZERO;
              state_nxt  = S_FIN;
            end else begin
              div_start = 1'b1;
              neg_nxt   = op_a[31] ^ op_b[31];
              state_nxt = S_DIV;
            end
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end

      S_MUL: begin
        // scale the magnitude so the shift truncates toward zero
        mag_nxt   = p_mag >> FRACTION_BITS;
        neg_nxt   = prod_r[63];
        state_nxt = S_SAT;
      end

      S_DIV: begin
        if (div_done) begin
          mag_nxt   = div_quo;
          state_nxt = S_SAT;
        end
      end

      S_SAT: begin
        commit_en = 1'b1;
        if (neg_r) begin
          commit_sat = (|mag_r[63:32]) || (mag_r[31] && (|mag_r[30:0]));
          commit_val = commit_sat ? 32'h8000_0000 : (32'd0 - mag_r[31:0]);
        end else begin
          commit_sat = |mag_r[63:31];
          commit_val = commit_sat ? 32'h7FFF_FFFF : mag_r[31:0];
        end
      end

      S_FIN: begin
        // hold until the output register is free, then report the new top
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.top_value   = (sp_r == '0) ? 32'sd0 : tos_r;
          out_data_nxt.stack_level = 5'(sp_r);
          out_data_nxt.status      = status_r;
          state_nxt                = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // pop two, push one: the result replaces A at sp-2 and becomes the top
    if (commit_en) begin
      wr_en      = 1'b1;
      wr_addr    = rd_addr;
      wr_data    = commit_val;
      tos_nxt    = commit_val;
      sp_nxt     = sp_r - SPW'(1);
      status_nxt = commit_sat ? ST_SAT : ST_OK;
      state_nxt  = S_FIN;
    end
  end

  always_ff @(posedge clk) begin
    tos_r      <= tos_nxt;
    op_r       <= op_nxt;
    status_r   <= status_nxt;
    prod_r     <= prod_nxt;
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= stack_mem[rd_addr];
    end
  end

  // take a new item only between items; a finished result may still wait
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/rpn_checker.sv
`timescale 1ns / 1ps

module rpn_checker import rpn_pkg::*; #(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one item at a time: no transfer in the cycle after a transfer
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken back to back");

  // empty stack reports zero on top
  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.stack_level == 5'd0) && (STACK_DEPTH < 32)
      |-> out_data.top_value == 32'sd0)
    else $error("nonzero top on empty stack");

  // level never exceeds the stack size
  a_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (STACK_DEPTH < 32) |-> 32'(out_data.stack_level) <= STACK_DEPTH)
    else $error("stack level out of range");

  // status is a defined code
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= ST_SAT)
    else $error("undefined status code");

endmodule

bind rpn_stack_evaluator rpn_checker #(
  .STACK_DEPTH(STACK_DEPTH)
) u_rpn_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
